@@ design/ebalu_pkg.sv @@
// shared types and constants for the 8-bit alu with flags
`timescale 1ns / 1ps

package ebalu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    KIND_ADD  = 5'd0,
    KIND_ADC  = 5'd1,
    KIND_SUB  = 5'd2,
    KIND_SBC  = 5'd3,
    KIND_AND  = 5'd4,
    KIND_XOR  = 5'd5,
    KIND_OR   = 5'd6,
    KIND_CP   = 5'd7,
    KIND_INC  = 5'd8,
    KIND_DEC  = 5'd9,
    KIND_DAA  = 5'd10,
    KIND_CPL  = 5'd11,
    KIND_CCF  = 5'd12,
    KIND_SCF  = 5'd13,
    KIND_RLC  = 5'd14,
    KIND_RRC  = 5'd15,
    KIND_RL   = 5'd16,
    KIND_RR   = 5'd17,
    KIND_SLA  = 5'd18,
    KIND_SRA  = 5'd19,
    KIND_SRL  = 5'd20,
    KIND_SWAP = 5'd21,
    KIND_BIT  = 5'd22,
    KIND_RES  = 5'd23,
    KIND_SET  = 5'd24
  } kind_e;

  // flag nibble, zero in the top bit
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // one operation as it sits in the input register
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] a;
    logic [7:0] b;
    logic [2:0] bit_index;
    flags_t     flags;
  } alu_op_t;

  // one result word
  typedef struct packed {
    logic [7:0] result;
    flags_t     flags;
    logic       write;
  } alu_res_t;

  // decimal adjust constants
  localparam logic [7:0] DAA_ADJ_LO = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] NIB_LIMIT  = 4'h9;
  localparam logic [3:0] NIB_MAX    = 4'hF;

endpackage

@@ design/ebalu_exec.sv @@
// combinational datapath: computes result byte, flags and write enable
`timescale 1ns / 1ps

module ebalu_exec import ebalu_pkg::*; (
  input  alu_op_t  op_i,
  output alu_res_t res_o
);

  kind_e      kind;
  logic       ci_add;
  logic       ci_sub;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] diff9;
  logic [4:0] hdiff5;
  logic [7:0] daa_adj;
  logic [7:0] bit_mask;
  logic [7:0] r;
  flags_t     f;
  flags_t     fi;
  logic       wr;

  assign kind = kind_e'(op_i.kind);
  assign fi   = op_i.flags;

  // carry in only for the with-carry forms
  assign ci_add = (kind == KIND_ADC) ? fi.c : 1'b0;
  assign ci_sub = (kind == KIND_SBC) ? fi.c : 1'b0;

  // shared adder and subtractor, nibble copies give the half carry
  assign sum9   = {1'b0, op_i.a} + {1'b0, op_i.b} + {8'd0, ci_add};
  assign hsum5  = {1'b0, op_i.a[3:0]} + {1'b0, op_i.b[3:0]} + {4'd0, ci_add};
  assign diff9  = {1'b0, op_i.a} - {1'b0, op_i.b} - {8'd0, ci_sub};
  assign hdiff5 = {1'b0, op_i.a[3:0]} - {1'b0, op_i.b[3:0]} - {4'd0, ci_sub};

  // decimal adjust correction
  always_comb begin
    daa_adj = 8'd0;
    if (!fi.n) begin
      if (fi.c || (op_i.a > DAA_LIMIT)) daa_adj = daa_adj | DAA_ADJ_HI;
      if (fi.h || (op_i.a[3:0] > NIB_LIMIT)) daa_adj = daa_adj | DAA_ADJ_LO;
    end else begin
      if (fi.c) daa_adj = daa_adj | DAA_ADJ_HI;
      if (fi.h) daa_adj = daa_adj | DAA_ADJ_LO;
    end
  end

  assign bit_mask = 8'd1 << op_i.bit_index;

  // operation select
  always_comb begin
    r  = op_i.a;
    f  = fi;
    wr = 1'b1;
    unique case (kind)
      KIND_ADD, KIND_ADC: begin
        r = sum9[7:0];
        f = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        r = diff9[7:0];
        f = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
        if (kind == KIND_CP) begin
          r  = op_i.a;
          wr = 1'b0;
        end
      end
      KIND_AND: begin
        r = op_i.a & op_i.b;
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      KIND_XOR: begin
        r = op_i.a ^ op_i.b;
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      KIND_OR: begin
        r = op_i.a | op_i.b;
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      KIND_INC: begin
        r = op_i.a + 8'd1;
        f = '{z: (r == 8'd0), n: 1'b0, h: (op_i.a[3:0] == NIB_MAX), c: fi.c};
      end
      KIND_DEC: begin
        r = op_i.a - 8'd1;
        f = '{z: (r == 8'd0), n: 1'b1, h: (op_i.a[3:0] == 4'd0), c: fi.c};
      end
      KIND_DAA: begin
        r = fi.n ? (op_i.a - daa_adj) : (op_i.a + daa_adj);
        f = '{z: (r == 8'd0), n: fi.n, h: 1'b0,
              c: fi.n ? fi.c : (fi.c || (op_i.a > DAA_LIMIT))};
      end
      KIND_CPL: begin
        r = ~op_i.a;
        f = '{z: fi.z, n: 1'b1, h: 1'b1, c: fi.c};
      end
      KIND_CCF: f = '{z: fi.z, n: 1'b0, h: 1'b0, c: ~fi.c};
      KIND_SCF: f = '{z: fi.z, n: 1'b0, h: 1'b0, c: 1'b1};
      KIND_RLC: begin
        r = {op_i.a[6:0], op_i.a[7]};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[7]};
      end
      KIND_RRC: begin
        r = {op_i.a[0], op_i.a[7:1]};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[0]};
      end
      KIND_RL: begin
        r = {op_i.a[6:0], fi.c};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[7]};
      end
      KIND_RR: begin
        r = {fi.c, op_i.a[7:1]};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[0]};
      end
      KIND_SLA: begin
        r = {op_i.a[6:0], 1'b0};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[7]};
      end
      KIND_SRA: begin
        r = {op_i.a[7], op_i.a[7:1]};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[0]};
      end
      KIND_SRL: begin
        r = {1'b0, op_i.a[7:1]};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: op_i.a[0]};
      end
      KIND_SWAP: begin
        r = {op_i.a[3:0], op_i.a[7:4]};
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      KIND_BIT: begin
        f  = '{z: ((op_i.a & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: fi.c};
        wr = 1'b0;
      end
      KIND_RES: r = op_i.a & ~bit_mask;
      KIND_SET: r = op_i.a | bit_mask;
      // unused codes pass the byte and flags through, no write
      default:  wr = 1'b0;
    endcase
  end

  assign res_o = '{result: r, flags: f, write: wr};

endmodule

@@ design/eight_bit_alu_with_flags_core.sv @@
// top level: input register, alu datapath and result register
// path: an accepted word moves from the input register through the datapath into the result register
// throughput: one word per cycle unless the output stalls; set by the datapath between the registers
// a stalled result holds in the output register while the input register still fills
// reset: rst_ni clears both valid bits asynchronously; payload registers are not reset
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_core import ebalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] kind_i,
  input  logic [7:0] operand_a_i,
  input  logic [7:0] operand_b_i,
  input  logic [2:0] bit_index_i,
  input  logic [3:0] flags_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] result_byte_o,
  output logic [3:0] flags_out_o,
  output logic       write_result_o
);

  logic     op_valid_q;
  logic     op_valid_d;
  alu_op_t  op_q;
  alu_res_t res;
  logic     out_valid_q;
  logic     out_valid_d;
  alu_res_t out_q;
  logic     out_load;
  logic     in_load;

  // stage handshakes
  assign out_load   = op_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !op_valid_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  assign op_valid_d  = in_load || (op_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      op_valid_q  <= op_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q <= '{kind: kind_i, a: operand_a_i, b: operand_b_i,
                bit_index: bit_index_i, flags: flags_t'(flags_in_i)};
    end
  end

  // datapath
  ebalu_exec u_exec (
    .op_i  (op_q),
    .res_o (res)
  );

  // result word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_byte_o  = out_q.result;
  assign flags_out_o    = out_q.flags;
  assign write_result_o = out_q.write;

  // a full input register never takes a word while the result stalls
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input register overwritten during output stall");

  // a word moving to the result stage shows up as valid next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("advanced word missing at output");

  // compare and bit test never write back
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && ((op_q.kind == KIND_CP) || (op_q.kind == KIND_BIT))) |-> !res.write)
    else $error("write enabled for compare or bit test");

  // additions always clear the negative flag
  a_add_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && ((op_q.kind == KIND_ADD) || (op_q.kind == KIND_ADC))) |-> !res.flags.n)
    else $error("negative flag set by addition");

endmodule

@@ tb/sv/eight_bit_alu_with_flags_core_test.sv @@
// self-checking testbench for the 8-bit alu with flags core
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_core_test;
  import ebalu_pkg::*;

  localparam logic [4:0] KIND_UNDEF_LO = 5'd25;
  localparam logic [4:0] KIND_UNDEF_HI = 5'd31;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 320;
  localparam int SHOWN_MISMATCHES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // sender side
  logic    in_valid = 1'b0;
  logic    in_ready;
  alu_op_t in_word = '0;
  logic    in_took = 1'b0;

  // receiver side
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] result_byte;
  logic [3:0] flags_out;
  logic       write_result;

  // phase controls
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic recv_hold = 1'b0;

  alu_op_t  op_backlog[$];
  alu_res_t due_results[$];
  int       mismatch_count = 0;

  eight_bit_alu_with_flags_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (in_word.kind),
    .operand_a_i    (in_word.a),
    .operand_b_i    (in_word.b),
    .bit_index_i    (in_word.bit_index),
    .flags_in_i     (in_word.flags),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_byte_o  (result_byte),
    .flags_out_o    (flags_out),
    .write_result_o (write_result)
  );

  always #5 clk_i = ~clk_i;

  // expected result of one alu word
  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t   r;
    logic       ci;
    logic       cy;
    logic [8:0] wide;
    logic [4:0] half;
    logic [7:0] mask;
    logic [7:0] adj;
    r.result = op.a;
    r.flags = op.flags;
    r.write = 1'b1;
    mask = 8'h01 << op.bit_index;
    case (op.kind)
      KIND_ADD, KIND_ADC: begin
        ci = (op.kind == KIND_ADC) ? op.flags.c : 1'b0;
        wide = {1'b0, op.a} + {1'b0, op.b} + {8'h00, ci};
        half = {1'b0, op.a[3:0]} + {1'b0, op.b[3:0]} + {4'h0, ci};
        r.result = wide[7:0];
        r.flags = {wide[7:0] == 8'h00, 1'b0, half[4], wide[8]};
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        ci = (op.kind == KIND_SBC) ? op.flags.c : 1'b0;
        wide = {1'b0, op.a} - {1'b0, op.b} - {8'h00, ci};
        half = {1'b0, op.a[3:0]} - {1'b0, op.b[3:0]} - {4'h0, ci};
        r.result = wide[7:0];
        r.flags = {wide[7:0] == 8'h00, 1'b1, half[4], wide[8]};
        // compare keeps the accumulator
        if (op.kind == KIND_CP) begin
          r.result = op.a;
          r.write = 1'b0;
        end
      end
      KIND_AND: begin
        r.result = op.a & op.b;
        r.flags = {r.result == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      KIND_XOR: begin
        r.result = op.a ^ op.b;
        r.flags = {r.result == 8'h00, 3'b000};
      end
      KIND_OR: begin
        r.result = op.a | op.b;
        r.flags = {r.result == 8'h00, 3'b000};
      end
      KIND_INC: begin
        r.result = op.a + 8'h01;
        r.flags = {r.result == 8'h00, 1'b0, op.a[3:0] == 4'hF, op.flags.c};
      end
      KIND_DEC: begin
        r.result = op.a - 8'h01;
        r.flags = {r.result == 8'h00, 1'b1, op.a[3:0] == 4'h0, op.flags.c};
      end
      KIND_DAA: begin
        // decimal adjust, direction from the negative flag
        adj = op.a;
        cy = op.flags.c;
        if (!op.flags.n) begin
          if (op.flags.c || op.a > 8'h99) begin
            adj = adj + 8'h60;
            cy = 1'b1;
          end
          if (op.flags.h || op.a[3:0] > 4'h9) adj = adj + 8'h06;
        end else begin
          if (op.flags.c) adj = adj - 8'h60;
          if (op.flags.h) adj = adj - 8'h06;
        end
        r.result = adj;
        r.flags = {adj == 8'h00, op.flags.n, 1'b0, cy};
      end
      KIND_CPL: begin
        r.result = ~op.a;
        r.flags = {op.flags.z, 1'b1, 1'b1, op.flags.c};
      end
      KIND_CCF: r.flags = {op.flags.z, 1'b0, 1'b0, ~op.flags.c};
      KIND_SCF: r.flags = {op.flags.z, 1'b0, 1'b0, 1'b1};
      KIND_RLC, KIND_RRC, KIND_RL, KIND_RR, KIND_SLA, KIND_SRA, KIND_SRL: begin
        case (op.kind)
          KIND_RLC: begin cy = op.a[7]; r.result = {op.a[6:0], op.a[7]}; end
          KIND_RRC: begin cy = op.a[0]; r.result = {op.a[0], op.a[7:1]}; end
          KIND_RL:  begin cy = op.a[7]; r.result = {op.a[6:0], op.flags.c}; end
          KIND_RR:  begin cy = op.a[0]; r.result = {op.flags.c, op.a[7:1]}; end
          KIND_SLA: begin cy = op.a[7]; r.result = {op.a[6:0], 1'b0}; end
          KIND_SRA: begin cy = op.a[0]; r.result = {op.a[7], op.a[7:1]}; end
          default:  begin cy = op.a[0]; r.result = {1'b0, op.a[7:1]}; end
        endcase
        r.flags = {r.result == 8'h00, 1'b0, 1'b0, cy};
      end
      KIND_SWAP: begin
        r.result = {op.a[3:0], op.a[7:4]};
        r.flags = {r.result == 8'h00, 3'b000};
      end
      KIND_BIT: begin
        r.flags = {(op.a & mask) == 8'h00, 1'b0, 1'b1, op.flags.c};
        r.write = 1'b0;
      end
      KIND_RES: r.result = op.a & ~mask;
      KIND_SET: r.result = op.a | mask;
      // undefined kinds pass everything through without a write
      default: r.write = 1'b0;
    endcase
    return r;
  endfunction

  function automatic alu_op_t make_op(logic [4:0] kind, logic [7:0] a, logic [7:0] b,
                                      logic [2:0] bit_index, logic [3:0] flags);
    alu_op_t op;
    op.kind = kind;
    op.a = a;
    op.b = b;
    op.bit_index = bit_index;
    op.flags = flags;
    return op;
  endfunction

  // operands lean toward nibble and byte edges
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = {4'($urandom_range(0, 15)), 4'hF};
      3: v = {4'($urandom_range(0, 15)), 4'h0};
      4: v = 8'($urandom_range(8'h90, 8'h9F));
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic alu_op_t random_op();
    logic [4:0] kind;
    if ($urandom_range(0, 19) == 0)
      kind = 5'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
    else
      kind = 5'($urandom_range(KIND_ADD, KIND_SET));
    return make_op(kind, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15)));
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (mismatch_count < SHOWN_MISMATCHES)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // returns once no word is queued, offered or in flight
  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // sender: new word after an accept or from idle, random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (op_backlog.size() != 0 &&
          !(send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)) begin
        in_word <= op_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    out_ready <= rst_ni && !recv_hold &&
                 !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin : watch_words
    alu_res_t want;
    if (rst_ni) begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected word, result", result_byte, 0);
        end else begin
          want = due_results.pop_front();
          if (result_byte !== want.result) report_mismatch("result", result_byte, want.result);
          if (flags_out !== want.flags) report_mismatch("flags", flags_out, want.flags);
          if (write_result !== want.write) report_mismatch("write", write_result, want.write);
        end
      end
      if (in_valid && in_ready) due_results.push_back(alu_predict(in_word));
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int ph;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every operation, byte edges, flag corner cases
    op_backlog.push_back(make_op(KIND_ADD, 8'hFF, 8'h01, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_ADC, 8'h0F, 8'h00, 3'd0, 4'h1));
    op_backlog.push_back(make_op(KIND_SUB, 8'h00, 8'h01, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_SBC, 8'h10, 8'hFF, 3'd0, 4'h1));
    op_backlog.push_back(make_op(KIND_AND, 8'h00, 8'hFF, 3'd0, 4'hF));
    op_backlog.push_back(make_op(KIND_XOR, 8'hFF, 8'hFF, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_OR, 8'hF0, 8'h0F, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_CP, 8'h42, 8'h42, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_INC, 8'hFF, 8'h00, 3'd0, 4'hF));
    op_backlog.push_back(make_op(KIND_DEC, 8'h00, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_DAA, 8'h9A, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_DAA, 8'h00, 8'h00, 3'd0, 4'h7));
    op_backlog.push_back(make_op(KIND_CPL, 8'h00, 8'h00, 3'd0, 4'h9));
    op_backlog.push_back(make_op(KIND_CCF, 8'hFF, 8'h00, 3'd0, 4'hF));
    op_backlog.push_back(make_op(KIND_SCF, 8'h00, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_RLC, 8'h80, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_RRC, 8'h01, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_RL, 8'h80, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_RR, 8'h01, 8'h00, 3'd0, 4'h1));
    op_backlog.push_back(make_op(KIND_SLA, 8'h80, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_SRA, 8'h81, 8'h00, 3'd0, 4'h0));
    op_backlog.push_back(make_op(KIND_SRL, 8'h01, 8'h00, 3'd0, 4'hF));
    op_backlog.push_back(make_op(KIND_SWAP, 8'hF0, 8'h00, 3'd0, 4'hF));
    op_backlog.push_back(make_op(KIND_BIT, 8'h7F, 8'h00, 3'd7, 4'h1));
    op_backlog.push_back(make_op(KIND_RES, 8'h01, 8'h00, 3'd0, 4'hA));
    op_backlog.push_back(make_op(KIND_SET, 8'h00, 8'h00, 3'd7, 4'h5));
    op_backlog.push_back(make_op(KIND_UNDEF_LO, 8'hFF, 8'hFF, 3'd7, 4'hA));
    op_backlog.push_back(make_op(KIND_UNDEF_HI, 8'h5A, 8'hA5, 3'd3, 4'h5));
    wait_drained();

    // random phases; sender pauses between them until everything is back
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; hold_go = 1'b1; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (PHASE_WORDS) op_backlog.push_back(random_op());
      wait_drained();
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("eight_bit_alu_with_flags_core regression: pass");
    end else begin
      $display("eight_bit_alu_with_flags_core regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("eight_bit_alu_with_flags_core regression: fail");
    $finish;
  end

endmodule
